// ===== rtl/bsm_pkg.sv =====
package bsm_pkg;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int ROOT_W  = DIFF_W;
    localparam int REM_W   = ROOT_W + 3;
    localparam int WIDE_W  = COORD_W + 4;
    localparam int CNT_W   = $clog2(ROOT_W);

    localparam logic signed [WIDE_W-1:0] SAT_HI = WIDE_W'((64'sd1 <<< (COORD_W - 1)) - 1);
    localparam logic signed [WIDE_W-1:0] SAT_LO = -SAT_HI - WIDE_W'(1);

    function automatic logic signed [COORD_W-1:0] sat(input logic signed [WIDE_W-1:0] v);
        logic signed [COORD_W-1:0] res;
        if (v > SAT_HI) begin
            res = SAT_HI[COORD_W-1:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[COORD_W-1:0];
        end else begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/bsm_csub.sv =====
module bsm_csub (
    input  logic [bsm_pkg::REM_W-1:0] i_rem_sh,
    input  logic [bsm_pkg::REM_W-1:0] i_trial,
    output logic                      o_ge,
    output logic [bsm_pkg::REM_W-1:0] o_rem
);

    assign o_ge  = (i_rem_sh >= i_trial);
    assign o_rem = o_ge ? (i_rem_sh - i_trial) : i_rem_sh;

endmodule

// ===== rtl/bounding_sphere_merge_top.sv =====
// Running enclosing sphere over a stream of spheres (center and radius in signed
// Q15.16). Every accepted word returns one word holding the running sphere. A word
// flagged first of list, or one with radius zero or less, goes straight to the
// output. A word that contains the running sphere, or lies inside it, goes through
// the squared center distance on the multiplier, a 33-step square root and one
// decision step. A word that sticks out goes through the same steps plus, for each
// axis, one multiply, a 33-step division and one update step, all through one
// 33x33 multiplier and one shared compare-subtract unit. The input stalls while a
// word is in work and while a finished result cannot leave the output register; a
// finished result waits there while the next word is taken.
module bounding_sphere_merge_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_first_of_list,
    input  logic signed [bsm_pkg::COORD_W-1:0] i_center_x,
    input  logic signed [bsm_pkg::COORD_W-1:0] i_center_y,
    input  logic signed [bsm_pkg::COORD_W-1:0] i_center_z,
    input  logic signed [bsm_pkg::COORD_W-1:0] i_sphere_radius,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [bsm_pkg::COORD_W-1:0] o_merged_x,
    output logic signed [bsm_pkg::COORD_W-1:0] o_merged_y,
    output logic signed [bsm_pkg::COORD_W-1:0] o_merged_z,
    output logic signed [bsm_pkg::COORD_W-1:0] o_merged_radius
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SQ    = 8'b0000_0010,
        S_SQRT  = 8'b0000_0100,
        S_DEC   = 8'b0000_1000,
        S_MUL   = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_APPLY = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state;

    logic signed [bsm_pkg::COORD_W-1:0] r_cx, r_cy, r_cz, r_r;
    logic signed [bsm_pkg::COORD_W-1:0] r_acc_x, r_acc_y, r_acc_z, r_acc_r;
    logic [1:0]                         r_axis;
    logic [bsm_pkg::CNT_W-1:0]          r_cnt;
    logic [bsm_pkg::PROD_W-1:0]         r_sum;
    logic [bsm_pkg::PROD_W-1:0]         r_prod;
    logic [bsm_pkg::ROOT_W-1:0]         r_root;
    logic [bsm_pkg::REM_W-1:0]          r_rem;
    logic [bsm_pkg::ROOT_W-1:0]         r_k;
    logic [bsm_pkg::ROOT_W-1:0]         r_q;
    logic                               r_ovalid;
    logic signed [bsm_pkg::COORD_W-1:0] r_ox, r_oy, r_oz, r_or;

    logic signed [bsm_pkg::COORD_W-1:0] sel_c, sel_acc;
    logic signed [bsm_pkg::DIFF_W-1:0]  diff;
    logic [bsm_pkg::DIFF_W-1:0]         mag;
    logic [bsm_pkg::DIFF_W-1:0]         mul_b;
    logic [bsm_pkg::PROD_W-1:0]         product;
    logic [bsm_pkg::REM_W-1:0]          rem_sh, trial, rem_nx;
    logic                               ge;
    logic signed [bsm_pkg::WIDE_W-1:0]  dd, ar, rr, sum3, nr, kk, moved;
    logic                               contain, sticks;
    logic signed [bsm_pkg::COORD_W-1:0] moved_sat;

    always_comb begin
        case (r_axis)
            2'd0:    begin sel_c = r_cx; sel_acc = r_acc_x; end
            2'd1:    begin sel_c = r_cy; sel_acc = r_acc_y; end
            default: begin sel_c = r_cz; sel_acc = r_acc_z; end
        endcase
    end

    assign diff    = bsm_pkg::DIFF_W'(sel_c) - bsm_pkg::DIFF_W'(sel_acc);
    assign mag     = diff[bsm_pkg::DIFF_W-1] ? bsm_pkg::DIFF_W'(-diff) : bsm_pkg::DIFF_W'(diff);
    assign mul_b   = (r_state == S_SQ) ? mag : r_k;
    assign product = bsm_pkg::PROD_W'(mag) * bsm_pkg::PROD_W'(mul_b);

    always_comb begin
        if (r_state == S_SQRT) begin
            rem_sh = {r_rem[bsm_pkg::REM_W-3:0], r_sum[bsm_pkg::PROD_W-1 -: 2]};
            trial  = bsm_pkg::REM_W'({r_root, 2'b01});
        end else begin
            rem_sh = {r_rem[bsm_pkg::REM_W-2:0], r_prod[bsm_pkg::ROOT_W-1]};
            trial  = bsm_pkg::REM_W'(r_root);
        end
    end

    bsm_csub u_csub (
        .i_rem_sh (rem_sh),
        .i_trial  (trial),
        .o_ge     (ge),
        .o_rem    (rem_nx)
    );

    assign dd      = bsm_pkg::WIDE_W'(signed'({1'b0, r_root}));
    assign ar      = bsm_pkg::WIDE_W'(r_acc_r);
    assign rr      = bsm_pkg::WIDE_W'(r_r);
    assign contain = (dd + ar) <= rr;
    assign sticks  = ((dd + rr) > ar) && (r_root != '0);
    assign sum3    = dd + rr + ar;
    assign nr      = sum3 >>> 1;
    assign kk      = nr - rr;

    assign moved = (!diff[bsm_pkg::DIFF_W-1])
                 ? bsm_pkg::WIDE_W'(sel_c) - bsm_pkg::WIDE_W'(signed'({1'b0, r_q}))
                 : bsm_pkg::WIDE_W'(sel_c) + bsm_pkg::WIDE_W'(signed'({1'b0, r_q}));
    assign moved_sat = bsm_pkg::sat(moved);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_acc_x  <= '0;
            r_acc_y  <= '0;
            r_acc_z  <= '0;
            r_acc_r  <= '0;
            r_axis   <= '0;
            r_cnt    <= '0;
        end else begin
            if (r_state == S_OUT && (!r_ovalid || !i_stall)) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cx   <= i_center_x;
                        r_cy   <= i_center_y;
                        r_cz   <= i_center_z;
                        r_r    <= i_sphere_radius;
                        r_axis <= '0;
                        r_cnt  <= '0;
                        r_sum  <= '0;
                        if (i_first_of_list) begin
                            r_acc_x <= i_center_x;
                            r_acc_y <= i_center_y;
                            r_acc_z <= i_center_z;
                            r_acc_r <= i_sphere_radius;
                            r_state <= S_OUT;
                        end else if (i_sphere_radius <= 0) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_SQ;
                        end
                    end
                end
                S_SQ: begin
                    r_prod <= product;
                    if (r_cnt != '0) begin
                        r_sum <= r_sum + r_prod;
                    end
                    if (r_cnt == bsm_pkg::CNT_W'(3)) begin
                        r_axis  <= '0;
                        r_cnt   <= bsm_pkg::CNT_W'(bsm_pkg::ROOT_W - 1);
                        r_root  <= '0;
                        r_rem   <= '0;
                        r_state <= S_SQRT;
                    end else begin
                        r_cnt  <= r_cnt + 1'b1;
                        r_axis <= r_axis + 1'b1;
                    end
                end
                S_SQRT: begin
                    r_rem  <= rem_nx;
                    r_root <= {r_root[bsm_pkg::ROOT_W-2:0], ge};
                    r_sum  <= {r_sum[bsm_pkg::PROD_W-3:0], 2'b00};
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (contain) begin
                        r_acc_x <= r_cx;
                        r_acc_y <= r_cy;
                        r_acc_z <= r_cz;
                        r_acc_r <= r_r;
                        r_state <= S_OUT;
                    end else if (sticks) begin
                        r_acc_r <= bsm_pkg::sat(nr);
                        r_k     <= kk[bsm_pkg::ROOT_W-1:0];
                        r_axis  <= '0;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_MUL: begin
                    r_rem   <= bsm_pkg::REM_W'(product[bsm_pkg::PROD_W-1:bsm_pkg::ROOT_W]);
                    r_prod  <= bsm_pkg::PROD_W'(product[bsm_pkg::ROOT_W-1:0]);
                    r_q     <= '0;
                    r_cnt   <= bsm_pkg::CNT_W'(bsm_pkg::ROOT_W - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= rem_nx;
                    r_q    <= {r_q[bsm_pkg::ROOT_W-2:0], ge};
                    r_prod <= {r_prod[bsm_pkg::PROD_W-2:0], 1'b0};
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    case (r_axis)
                        2'd0:    r_acc_x <= moved_sat;
                        2'd1:    r_acc_y <= moved_sat;
                        default: r_acc_z <= moved_sat;
                    endcase
                    if (r_axis == 2'd2) begin
                        r_state <= S_OUT;
                    end else begin
                        r_axis  <= r_axis + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ox     <= r_acc_x;
                        r_oy     <= r_acc_y;
                        r_oz     <= r_acc_z;
                        r_or     <= r_acc_r;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_ovalid;
    assign o_merged_x      = r_ox;
    assign o_merged_y      = r_oy;
    assign o_merged_z      = r_oz;
    assign o_merged_radius = r_or;

    a_first_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid && i_first_of_list)
        |=> (r_acc_x == $past(i_center_x) && r_acc_r == $past(i_sphere_radius)))
        else $error("first word not loaded");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < bsm_pkg::REM_W'(r_root)))
        else $error("division remainder out of range");

    a_out_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && (!r_ovalid || !i_stall)) |=> (r_ovalid && r_state == S_IDLE))
        else $error("result not delivered");

endmodule
